/* sv/lrs_pkg.sv */
package lrs_pkg;

    // Event codes carried by the action field.
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SEND   = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_START  = 2'd3
    } action_t;

    // Stack status report kinds; any other code is treated as "other".
    typedef enum logic [1:0] {
        ST_NET_UP   = 2'd0,
        ST_NET_DOWN = 2'd1,
        ST_OTHER    = 2'd2
    } status_kind_t;

    // Stack network state sampled at a tick; other codes are transitional.
    typedef enum logic [1:0] {
        NS_NONE   = 2'd0,
        NS_JOINED = 2'd1,
        NS_TRANS  = 2'd2
    } net_state_t;

    // Announce timer commands.
    typedef enum logic [1:0] {
        ANN_NONE  = 2'd0,
        ANN_START = 2'd1,
        ANN_STOP  = 2'd2
    } announce_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_RETRY_MIN    = 3'd0,
        CFG_RETRY_MAX    = 3'd1,
        CFG_FIRST_DELAY  = 3'd2,
        CFG_STALL_TMO    = 3'd3,
        CFG_FAIL_LIMIT   = 3'd4,
        CFG_GIVEUP       = 3'd5,
        CFG_STABLE       = 3'd6,
        CFG_BOOT_TMO     = 3'd7
    } cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register values after reset.
    localparam logic [15:0] RST_RETRY_MIN   = 16'd2000;
    localparam logic [15:0] RST_RETRY_MAX   = 16'd20000;
    localparam logic [15:0] RST_FIRST_DELAY = 16'd300;
    localparam logic [31:0] RST_STALL_TMO   = 32'd15000;
    localparam logic [3:0]  RST_FAIL_LIMIT  = 4'd3;
    localparam logic [31:0] RST_GIVEUP      = 32'd300000;
    localparam logic [31:0] RST_STABLE      = 32'd15000;
    localparam logic [31:0] RST_BOOT_TMO    = 32'd180000;

    localparam logic [3:0] FAIL_COUNT_MAX = 4'hF;

    // One event beat as held in the input register.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        send_ok;
        logic [1:0]  status_kind;
        logic        own_is_coordinator;
        logic [1:0]  radio_net_state;
        logic        join_accepted;
        logic        on_probation;
    } event_t;

    // One result beat as held in the output register.
    typedef struct packed {
        logic        system_reset;
        logic        clear_net_state;
        logic        join_request;
        logic        confirm_healthy;
        logic        sleep_blocked;
        logic [1:0]  announce_cmd;
        logic        joined_now;
        logic [15:0] retry_interval;
    } result_t;

endpackage

/* sv/link_rejoin_supervisor.sv */
// Link rejoin supervisor. Each input beat is one event (tick, send completion,
// stack status report or initial start) and produces exactly one result beat
// carrying the recovery commands for that event together with the joined flag,
// the sleep block flag and the current retry interval. The block takes one
// event per clock cycle when the result side is not stalled: an event is
// captured in an input register, all decisions for it are made in a single
// pass of comparison and update logic against the supervisor state, and the
// result lands in an output register when the input register advances.
// Throughput is set by that single registered pass; the output register lets
// a new event enter while the previous result is still waiting to be taken.
// All time differences wrap modulo 2^32. Configuration registers are written
// through cfg_we / cfg_index / cfg_data and should only be changed while no
// event is in flight.
module link_rejoin_supervisor
    import lrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            action,
    input  logic [31:0]           now_ms,
    input  logic                  send_ok,
    input  logic [1:0]            status_kind,
    input  logic                  own_is_coordinator,
    input  logic [1:0]            radio_net_state,
    input  logic                  join_accepted,
    input  logic                  on_probation,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  system_reset,
    output logic                  clear_net_state,
    output logic                  join_request,
    output logic                  confirm_healthy,
    output logic                  sleep_blocked,
    output logic [1:0]            announce_cmd,
    output logic                  joined_now,
    output logic [15:0]           retry_interval
);

    // Configuration registers.
    logic [15:0] retry_min_reg;
    logic [15:0] retry_max_reg;
    logic [15:0] first_delay_reg;
    logic [31:0] stall_tmo_reg;
    logic [3:0]  fail_limit_reg;
    logic [31:0] giveup_reg;
    logic [31:0] stable_reg;
    logic [31:0] boot_tmo_reg;

    // Supervisor state.
    logic        joined_reg,         joined_next;
    logic        joining_reg,        joining_next;
    logic [31:0] anchor_reg,         anchor_next;
    logic [15:0] backoff_reg,        backoff_next;
    logic [3:0]  fail_count_reg,     fail_count_next;
    logic [31:0] unjoined_start_reg, unjoined_start_next;
    logic        unjoined_valid_reg, unjoined_valid_next;
    logic [31:0] up_time_reg,        up_time_next;
    logic        up_valid_reg,       up_valid_next;
    logic        healthy_reg,        healthy_next;
    logic [31:0] boot_time_reg,      boot_time_next;
    logic        boot_seen_reg,      boot_seen_next;
    logic        stale_reg,          stale_next;
    logic        sleep_block_reg,    sleep_block_next;

    // Pipeline registers.
    logic    ev_valid_reg, ev_valid_next;
    event_t  ev_reg;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    result_t res_next;

    logic    in_accept;
    logic    advance;

    // Working values of the single pass.
    logic        rst_cmd;
    logic        clr_cmd;
    logic        jreq_cmd;
    logic        conf_cmd;
    announce_t   ann_cmd;
    logic [15:0] pull;
    logic [31:0] elapsed;
    logic [16:0] doubled;
    logic [3:0]  fc_inc;

    // ------------------------------------------------------------------
    // Handshake. The event register advances into the result register
    // whenever the result register is empty or its beat is being taken.
    // ------------------------------------------------------------------
    assign advance   = ev_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = ev_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        ev_valid_next = ev_valid_reg;
        if (in_accept)
        begin
            ev_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ev_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Event processing: one pass over the buffered event and the state.
    // ------------------------------------------------------------------
    always_comb
    begin
        joined_next         = joined_reg;
        joining_next        = joining_reg;
        anchor_next         = anchor_reg;
        backoff_next        = backoff_reg;
        fail_count_next     = fail_count_reg;
        unjoined_start_next = unjoined_start_reg;
        unjoined_valid_next = unjoined_valid_reg;
        up_time_next        = up_time_reg;
        up_valid_next       = up_valid_reg;
        healthy_next        = healthy_reg;
        boot_time_next      = boot_time_reg;
        boot_seen_next      = boot_seen_reg;
        stale_next          = stale_reg;
        sleep_block_next    = sleep_block_reg;

        rst_cmd  = 1'b0;
        clr_cmd  = 1'b0;
        jreq_cmd = 1'b0;
        conf_cmd = 1'b0;
        ann_cmd  = ANN_NONE;

        // The anchor is pulled back so the first join follows after first_delay;
        // the pull-back stops at zero when the delay exceeds the minimum interval.
        pull    = (retry_min_reg > first_delay_reg) ? (retry_min_reg - first_delay_reg)
                                                    : 16'd0;
        elapsed = ev_reg.now_ms - anchor_reg;
        doubled = 17'd0;
        fc_inc  = (fail_count_reg != FAIL_COUNT_MAX) ? (fail_count_reg + 4'd1)
                                                      : fail_count_reg;

        case (ev_reg.action)
            ACT_START:
            begin
                sleep_block_next    = 1'b1;
                backoff_next        = retry_min_reg;
                unjoined_valid_next = 1'b0;
                anchor_next         = ev_reg.now_ms - {16'd0, pull};
            end
            ACT_SEND:
            begin
                if (ev_reg.send_ok)
                begin
                    fail_count_next = 4'd0;
                end
                else if (joined_reg)
                begin
                    fail_count_next = fc_inc;
                    if (fc_inc >= fail_limit_reg)
                    begin
                        // Too many failed sends: drop to a soft rejoin.
                        fail_count_next = 4'd0;
                        joined_next     = 1'b0;
                        backoff_next    = retry_min_reg;
                        anchor_next     = ev_reg.now_ms;
                    end
                end
            end
            ACT_STATUS:
            begin
                case (ev_reg.status_kind)
                    ST_NET_UP:
                    begin
                        if (ev_reg.own_is_coordinator)
                        begin
                            // Stale coordinator identity: recover on the next tick.
                            joined_next   = 1'b0;
                            joining_next  = 1'b0;
                            up_valid_next = 1'b0;
                            stale_next    = 1'b1;
                            ann_cmd       = ANN_STOP;
                        end
                        else
                        begin
                            joined_next      = 1'b1;
                            joining_next     = 1'b0;
                            backoff_next     = retry_min_reg;
                            fail_count_next  = 4'd0;
                            sleep_block_next = 1'b0;
                            up_time_next     = ev_reg.now_ms;
                            up_valid_next    = 1'b1;
                            ann_cmd          = ANN_START;
                        end
                    end
                    ST_NET_DOWN:
                    begin
                        joined_next      = 1'b0;
                        joining_next     = 1'b0;
                        up_valid_next    = 1'b0;
                        backoff_next     = retry_min_reg;
                        sleep_block_next = 1'b1;
                        anchor_next      = ev_reg.now_ms;
                        ann_cmd          = ANN_STOP;
                    end
                    default:
                    begin
                        if (joining_reg)
                        begin
                            joining_next = 1'b0;
                            anchor_next  = ev_reg.now_ms;
                        end
                    end
                endcase
            end
            default:
            begin
                // Tick.
                if (stale_reg)
                begin
                    stale_next = 1'b0;
                    rst_cmd    = 1'b1;
                    clr_cmd    = 1'b1;
                end
                else
                begin
                    if (!boot_seen_reg)
                    begin
                        boot_time_next = ev_reg.now_ms;
                        boot_seen_next = 1'b1;
                    end
                    if (!healthy_reg)
                    begin
                        if (joined_reg && up_valid_reg
                            && ((ev_reg.now_ms - up_time_reg) >= stable_reg))
                        begin
                            conf_cmd     = 1'b1;
                            healthy_next = 1'b1;
                        end
                        else if (ev_reg.on_probation
                                 && ((ev_reg.now_ms - boot_time_next) >= boot_tmo_reg))
                        begin
                            rst_cmd = 1'b1;
                        end
                    end
                    if (!rst_cmd)
                    begin
                        if (!joined_reg)
                        begin
                            sleep_block_next = 1'b1;
                            if (!unjoined_valid_reg)
                            begin
                                unjoined_start_next = ev_reg.now_ms;
                                unjoined_valid_next = 1'b1;
                            end
                            else if ((ev_reg.now_ms - unjoined_start_reg) > giveup_reg)
                            begin
                                rst_cmd = 1'b1;
                            end

                            if (!rst_cmd)
                            begin
                                if (joining_reg)
                                begin
                                    if (elapsed > stall_tmo_reg)
                                    begin
                                        // Join hung: abort it and restart the backoff.
                                        joining_next = 1'b0;
                                        clr_cmd      = (ev_reg.radio_net_state != NS_NONE);
                                        backoff_next = retry_min_reg;
                                        anchor_next  = ev_reg.now_ms;
                                    end
                                end
                                else if (elapsed >= {16'd0, backoff_reg})
                                begin
                                    if (ev_reg.radio_net_state == NS_JOINED)
                                    begin
                                        // Stack still believes it is joined.
                                        clr_cmd      = 1'b1;
                                        backoff_next = retry_min_reg;
                                        anchor_next  = ev_reg.now_ms;
                                    end
                                    else if (ev_reg.radio_net_state == NS_NONE)
                                    begin
                                        anchor_next  = ev_reg.now_ms;
                                        jreq_cmd     = 1'b1;
                                        joining_next = ev_reg.join_accepted;
                                    end
                                    doubled      = {backoff_next, 1'b0};
                                    backoff_next = (doubled > {1'b0, retry_max_reg})
                                                 ? retry_max_reg : doubled[15:0];
                                end
                            end
                        end
                        else
                        begin
                            unjoined_valid_next = 1'b0;
                        end
                    end
                end
            end
        endcase

        res_next.system_reset    = rst_cmd;
        res_next.clear_net_state = clr_cmd;
        res_next.join_request    = jreq_cmd;
        res_next.confirm_healthy = conf_cmd;
        res_next.sleep_blocked   = sleep_block_next;
        res_next.announce_cmd    = ann_cmd;
        res_next.joined_now      = joined_next;
        res_next.retry_interval  = backoff_next;
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_min_reg   <= RST_RETRY_MIN;
            retry_max_reg   <= RST_RETRY_MAX;
            first_delay_reg <= RST_FIRST_DELAY;
            stall_tmo_reg   <= RST_STALL_TMO;
            fail_limit_reg  <= RST_FAIL_LIMIT;
            giveup_reg      <= RST_GIVEUP;
            stable_reg      <= RST_STABLE;
            boot_tmo_reg    <= RST_BOOT_TMO;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RETRY_MIN:   retry_min_reg   <= cfg_data[15:0];
                CFG_RETRY_MAX:   retry_max_reg   <= cfg_data[15:0];
                CFG_FIRST_DELAY: first_delay_reg <= cfg_data[15:0];
                CFG_STALL_TMO:   stall_tmo_reg   <= cfg_data;
                CFG_FAIL_LIMIT:  fail_limit_reg  <= cfg_data[3:0];
                CFG_GIVEUP:      giveup_reg      <= cfg_data;
                CFG_STABLE:      stable_reg      <= cfg_data;
                CFG_BOOT_TMO:    boot_tmo_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State, handshake and pipeline registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joined_reg         <= 1'b0;
            joining_reg        <= 1'b0;
            anchor_reg         <= 32'd0;
            backoff_reg        <= RST_RETRY_MIN;
            fail_count_reg     <= 4'd0;
            unjoined_start_reg <= 32'd0;
            unjoined_valid_reg <= 1'b0;
            up_time_reg        <= 32'd0;
            up_valid_reg       <= 1'b0;
            healthy_reg        <= 1'b0;
            boot_time_reg      <= 32'd0;
            boot_seen_reg      <= 1'b0;
            stale_reg          <= 1'b0;
            sleep_block_reg    <= 1'b0;
            ev_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                joined_reg         <= joined_next;
                joining_reg        <= joining_next;
                anchor_reg         <= anchor_next;
                backoff_reg        <= backoff_next;
                fail_count_reg     <= fail_count_next;
                unjoined_start_reg <= unjoined_start_next;
                unjoined_valid_reg <= unjoined_valid_next;
                up_time_reg        <= up_time_next;
                up_valid_reg       <= up_valid_next;
                healthy_reg        <= healthy_next;
                boot_time_reg      <= boot_time_next;
                boot_seen_reg      <= boot_seen_next;
                stale_reg          <= stale_next;
                sleep_block_reg    <= sleep_block_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ev_reg.action             <= action;
            ev_reg.now_ms             <= now_ms;
            ev_reg.send_ok            <= send_ok;
            ev_reg.status_kind        <= status_kind;
            ev_reg.own_is_coordinator <= own_is_coordinator;
            ev_reg.radio_net_state    <= radio_net_state;
            ev_reg.join_accepted      <= join_accepted;
            ev_reg.on_probation       <= on_probation;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign system_reset    = res_reg.system_reset;
    assign clear_net_state = res_reg.clear_net_state;
    assign join_request    = res_reg.join_request;
    assign confirm_healthy = res_reg.confirm_healthy;
    assign sleep_blocked   = res_reg.sleep_blocked;
    assign announce_cmd    = res_reg.announce_cmd;
    assign joined_now      = res_reg.joined_now;
    assign retry_interval  = res_reg.retry_interval;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A beat is refused only while an event is buffered and cannot move on.
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (ev_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked event");

    // A join attempt never goes out together with a reset or a state clear.
    a_join_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(join_request && (system_reset || clear_net_state)))
        else $error("join request combined with reset or clear");

    // Health confirmation is reported once and is then remembered for good.
    a_confirm_sets_healthy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.confirm_healthy) |=> healthy_reg)
        else $error("health confirmed but flag not set");

    a_healthy_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        healthy_reg |=> healthy_reg)
        else $error("healthy flag dropped");

    // The announce command uses only its three defined codes.
    a_announce_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (announce_cmd != 2'd3))
        else $error("undefined announce command");

endmodule

/* tb/tb_link_rejoin_supervisor.sv */
module tb_link_rejoin_supervisor;
    import lrs_pkg::*;

    // One row of the directed script. A row with a pinned result carries the value that is
    // expected on the output. Every other row is checked against the membership model below.
    typedef struct packed {
        event_t  ev;
        bit      pinned;
        result_t want;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            action = '0;
    logic [31:0]           now_ms = '0;
    logic                  send_ok = 1'b0;
    logic [1:0]            status_kind = '0;
    logic                  own_is_coordinator = 1'b0;
    logic [1:0]            radio_net_state = '0;
    logic                  join_accepted = 1'b0;
    logic                  on_probation = 1'b0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  system_reset;
    logic                  clear_net_state;
    logic                  join_request;
    logic                  confirm_healthy;
    logic                  sleep_blocked;
    logic [1:0]            announce_cmd;
    logic                  joined_now;
    logic [15:0]           retry_interval;

    link_rejoin_supervisor u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .now_ms             (now_ms),
        .send_ok            (send_ok),
        .status_kind        (status_kind),
        .own_is_coordinator (own_is_coordinator),
        .radio_net_state    (radio_net_state),
        .join_accepted      (join_accepted),
        .on_probation       (on_probation),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .system_reset       (system_reset),
        .clear_net_state    (clear_net_state),
        .join_request       (join_request),
        .confirm_healthy    (confirm_healthy),
        .sleep_blocked      (sleep_blocked),
        .announce_cmd       (announce_cmd),
        .joined_now         (joined_now),
        .retry_interval     (retry_interval)
    );

    always #5 clk = ~clk;

    // Shadow copy of the configuration registers. It is updated at the same clock edge at
    // which the write reaches the block, and writes only happen while nothing is in flight.
    logic [15:0] set_retry_min   = RST_RETRY_MIN;
    logic [15:0] set_retry_max   = RST_RETRY_MAX;
    logic [15:0] set_first_delay = RST_FIRST_DELAY;
    logic [31:0] set_stall_tmo   = RST_STALL_TMO;
    logic [3:0]  set_fail_limit  = RST_FAIL_LIMIT;
    logic [31:0] set_giveup      = RST_GIVEUP;
    logic [31:0] set_stable      = RST_STABLE;
    logic [31:0] set_boot_tmo    = RST_BOOT_TMO;

    // Membership state as the model sees it. A separate valid bit stands in for each
    // timestamp that may be unset, so a timestamp of zero is an ordinary time.
    logic        net_joined   = 1'b0;
    logic        join_busy    = 1'b0;
    logic [31:0] retry_anchor = '0;
    logic [15:0] retry_gap    = RST_RETRY_MIN;
    logic [3:0]  send_fails   = '0;
    logic [31:0] lost_since   = '0;
    logic        lost_ok      = 1'b0;
    logic [31:0] link_up_at   = '0;
    logic        link_up_ok   = 1'b0;
    logic        fw_healthy   = 1'b0;
    logic [31:0] boot_at      = '0;
    logic        boot_ok      = 1'b0;
    logic        stale_coord  = 1'b0;
    logic        hold_awake   = 1'b0;

    result_t     pending_results[$];
    script_row_t script[$];
    result_t     arrived_want;

    int unsigned error_count   = 0;
    int unsigned beats_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned joins_seen    = 0;
    int unsigned clears_seen   = 0;
    int unsigned resets_seen   = 0;
    int unsigned confirms_seen = 0;

    // Random traffic keeps its own wall clock so that most timestamps move forward the way
    // a real millisecond counter does. The step size is tuned to each register setting.
    logic [31:0] wall_ms     = '0;
    int unsigned step_scale  = 3000;
    bit          steady_span = 1'b0;

    // The three fields that always mirror the current state are filled in at every exit.
    function automatic result_t with_state(result_t r);
        r.sleep_blocked  = hold_awake;
        r.joined_now     = net_joined;
        r.retry_interval = retry_gap;
        return r;
    endfunction

    // Works out the result of one event and advances the membership state.
    function automatic result_t supervise(event_t ev);
        result_t     r;
        logic [15:0] pull;
        logic [31:0] since;
        logic [31:0] doubled;
        r = '0;
        if (ev.action == ACT_START)
        begin
            // The anchor is pulled back so that the first join comes after the first delay.
            // When the first delay is above the minimum the pull-back stops at zero.
            pull = (set_retry_min > set_first_delay) ? set_retry_min - set_first_delay : 16'd0;
            hold_awake   = 1'b1;
            retry_gap    = set_retry_min;
            lost_ok      = 1'b0;
            retry_anchor = ev.now_ms - {16'd0, pull};
        end
        else if (ev.action == ACT_SEND)
        begin
            if (ev.send_ok)
            begin
                send_fails = '0;
            end
            else if (net_joined)
            begin
                if (send_fails < FAIL_COUNT_MAX)
                begin
                    send_fails = send_fails + 4'd1;
                end
                if (send_fails >= set_fail_limit)
                begin
                    send_fails   = '0;
                    net_joined   = 1'b0;
                    retry_gap    = set_retry_min;
                    retry_anchor = ev.now_ms;
                end
            end
        end
        else if (ev.action == ACT_STATUS)
        begin
            if (ev.status_kind == ST_NET_UP)
            begin
                if (ev.own_is_coordinator)
                begin
                    // Our own address claims to be the coordinator: the stored network is
                    // stale, and the next tick asks for a clear and a reset.
                    net_joined  = 1'b0;
                    join_busy   = 1'b0;
                    link_up_ok  = 1'b0;
                    stale_coord = 1'b1;
                    r.announce_cmd = ANN_STOP;
                end
                else
                begin
                    net_joined = 1'b1;
                    join_busy  = 1'b0;
                    retry_gap  = set_retry_min;
                    send_fails = '0;
                    hold_awake = 1'b0;
                    link_up_at = ev.now_ms;
                    link_up_ok = 1'b1;
                    r.announce_cmd = ANN_START;
                end
            end
            else if (ev.status_kind == ST_NET_DOWN)
            begin
                net_joined   = 1'b0;
                join_busy    = 1'b0;
                link_up_ok   = 1'b0;
                retry_gap    = set_retry_min;
                hold_awake   = 1'b1;
                retry_anchor = ev.now_ms;
                r.announce_cmd = ANN_STOP;
            end
            else if (join_busy)
            begin
                join_busy    = 1'b0;
                retry_anchor = ev.now_ms;
            end
        end
        else
        begin
            if (stale_coord)
            begin
                stale_coord       = 1'b0;
                r.system_reset    = 1'b1;
                r.clear_net_state = 1'b1;
                return with_state(r);
            end
            if (!boot_ok)
            begin
                boot_at = ev.now_ms;
                boot_ok = 1'b1;
            end
            if (!fw_healthy)
            begin
                since = ev.now_ms - link_up_at;
                if (net_joined && link_up_ok && since >= set_stable)
                begin
                    r.confirm_healthy = 1'b1;
                    fw_healthy        = 1'b1;
                end
                else
                begin
                    since = ev.now_ms - boot_at;
                    if (ev.on_probation && since >= set_boot_tmo)
                    begin
                        r.system_reset = 1'b1;
                        return with_state(r);
                    end
                end
            end
            if (!net_joined)
            begin
                hold_awake = 1'b1;
                since = ev.now_ms - lost_since;
                if (!lost_ok)
                begin
                    lost_since = ev.now_ms;
                    lost_ok    = 1'b1;
                end
                else if (since > set_giveup)
                begin
                    // Unjoined for too long; a health confirmation from this tick stays.
                    r.system_reset = 1'b1;
                    return with_state(r);
                end
                since = ev.now_ms - retry_anchor;
                if (join_busy)
                begin
                    if (since > set_stall_tmo)
                    begin
                        join_busy = 1'b0;
                        if (ev.radio_net_state != NS_NONE)
                        begin
                            r.clear_net_state = 1'b1;
                        end
                        retry_gap    = set_retry_min;
                        retry_anchor = ev.now_ms;
                    end
                end
                else if (since >= {16'd0, retry_gap})
                begin
                    if (ev.radio_net_state == NS_JOINED)
                    begin
                        // The stack still thinks it is joined, so clear it instead of joining.
                        r.clear_net_state = 1'b1;
                        retry_gap         = set_retry_min;
                        retry_anchor      = ev.now_ms;
                    end
                    else if (ev.radio_net_state == NS_NONE)
                    begin
                        retry_anchor   = ev.now_ms;
                        r.join_request = 1'b1;
                        join_busy      = ev.join_accepted;
                    end
                    // The interval doubles after every attempt, also a transitional one.
                    doubled   = {15'd0, retry_gap, 1'b0};
                    retry_gap = (doubled > {16'd0, set_retry_max}) ? set_retry_max
                                                                    : doubled[15:0];
                end
            end
            else
            begin
                lost_ok = 1'b0;
            end
        end
        return with_state(r);
    endfunction

    function automatic result_t make_result(bit rst, bit clr, bit jreq, bit conf, bit sleep,
                                            announce_t ann, bit joined, logic [15:0] gap);
        result_t r;
        r.system_reset    = rst;
        r.clear_net_state = clr;
        r.join_request    = jreq;
        r.confirm_healthy = conf;
        r.sleep_blocked   = sleep;
        r.announce_cmd    = ann;
        r.joined_now      = joined;
        r.retry_interval  = gap;
        return r;
    endfunction

    function automatic void script_add(logic [1:0] act, logic [31:0] t, bit ok,
                                       logic [1:0] kind, bit coord, logic [1:0] ns,
                                       bit acc, bit prob);
        script_row_t row;
        row.ev.action             = act;
        row.ev.now_ms             = t;
        row.ev.send_ok            = ok;
        row.ev.status_kind        = kind;
        row.ev.own_is_coordinator = coord;
        row.ev.radio_net_state    = ns;
        row.ev.join_accepted      = acc;
        row.ev.on_probation       = prob;
        row.pinned                = 1'b0;
        row.want                  = '0;
        script.push_back(row);
    endfunction

    // Pins the expected result of the row that was added last.
    function automatic void script_pin(result_t r);
        script_row_t row;
        row        = script.pop_back();
        row.pinned = 1'b1;
        row.want   = r;
        script.push_back(row);
    endfunction

    // Draws one event. While unjoined most events are ticks that drive the retry logic;
    // once joined, send completions dominate so that the failure counter gets exercised.
    function automatic event_t next_random_event();
        event_t      ev;
        int unsigned pick;
        int unsigned lane;
        pick = $urandom_range(0, 99);
        lane = $urandom_range(0, 99);
        if (lane < 85)
        begin
            wall_ms = wall_ms + $urandom_range(0, step_scale);
        end
        else if (lane < 97)
        begin
            wall_ms = wall_ms + $urandom_range(0, 20 * step_scale);
        end
        else
        begin
            wall_ms = $urandom;
        end
        if (net_joined)
        begin
            ev.action = (pick < 35) ? ACT_TICK : (pick < 75) ? ACT_SEND :
                        (pick < 97) ? ACT_STATUS : ACT_START;
        end
        else
        begin
            ev.action = (pick < 65) ? ACT_TICK : (pick < 72) ? ACT_SEND :
                        (pick < 97) ? ACT_STATUS : ACT_START;
        end
        ev.now_ms  = wall_ms;
        ev.send_ok = ($urandom_range(0, 99) < 55);
        pick = $urandom_range(0, 99);
        ev.status_kind = (pick < 45) ? ST_NET_UP : (pick < 70) ? ST_NET_DOWN :
                         2'($urandom_range(ST_OTHER, 3));
        ev.own_is_coordinator = ($urandom_range(0, 99) < 10);
        pick = $urandom_range(0, 99);
        ev.radio_net_state = (pick < 55) ? NS_NONE : (pick < 75) ? NS_JOINED :
                             2'($urandom_range(NS_TRANS, 3));
        ev.join_accepted = ($urandom_range(0, 99) < 70);
        ev.on_probation  = ($urandom_range(0, 99) < 15);
        return ev;
    endfunction

    // Presents one event beat, with random gaps in front of it, and records what the model
    // expects once the beat has been taken.
    task automatic deliver(input event_t ev, input bit pinned, input result_t want);
        result_t predicted;
        while (!steady_span && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        action             <= ev.action;
        now_ms             <= ev.now_ms;
        send_ok            <= ev.send_ok;
        status_kind        <= ev.status_kind;
        own_is_coordinator <= ev.own_is_coordinator;
        radio_net_state    <= ev.radio_net_state;
        join_accepted      <= ev.join_accepted;
        on_probation       <= ev.on_probation;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        predicted = supervise(ev);
        pending_results.push_back(pinned ? want : predicted);
        beats_sent++;
    endtask

    // Waits for every outstanding result and then for the pipeline to settle.
    task automatic drain();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Drives one register write; the caller lowers the write enable after the last one.
    task automatic put_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_RETRY_MIN:   set_retry_min   = value[15:0];
            CFG_RETRY_MAX:   set_retry_max   = value[15:0];
            CFG_FIRST_DELAY: set_first_delay = value[15:0];
            CFG_STALL_TMO:   set_stall_tmo   = value;
            CFG_FAIL_LIMIT:  set_fail_limit  = value[3:0];
            CFG_GIVEUP:      set_giveup      = value;
            CFG_STABLE:      set_stable      = value;
            CFG_BOOT_TMO:    set_boot_tmo    = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] rmin, input logic [15:0] rmax,
                                  input logic [15:0] first, input logic [31:0] stall,
                                  input logic [3:0] fails, input logic [31:0] giveup,
                                  input logic [31:0] stable, input logic [31:0] boot);
        put_reg(CFG_RETRY_MIN, {16'd0, rmin});
        put_reg(CFG_RETRY_MAX, {16'd0, rmax});
        put_reg(CFG_FIRST_DELAY, {16'd0, first});
        put_reg(CFG_STALL_TMO, stall);
        put_reg(CFG_FAIL_LIMIT, {28'd0, fails});
        put_reg(CFG_GIVEUP, giveup);
        put_reg(CFG_STABLE, stable);
        put_reg(CFG_BOOT_TMO, boot);
        cfg_we <= 1'b0;
    endtask

    function automatic void match_field(string field, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: mismatch on %s, expected %0h, got %0h", $time, field, exp, act);
            error_count++;
        end
    endfunction

    // The result side stalls at random, except during the steady stretch.
    always @(posedge clk)
    begin
        out_stall <= !steady_span && ($urandom_range(0, 99) < 16);
    end

    // Every result beat is compared field by field with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %0h", $time,
                         {system_reset, clear_net_state, join_request, confirm_healthy,
                          sleep_blocked, announce_cmd, joined_now, retry_interval});
                error_count++;
            end
            else
            begin
                arrived_want = pending_results.pop_front();
                match_field("system_reset", 32'(arrived_want.system_reset),
                            32'(system_reset));
                match_field("clear_net_state", 32'(arrived_want.clear_net_state),
                            32'(clear_net_state));
                match_field("join_request", 32'(arrived_want.join_request),
                            32'(join_request));
                match_field("confirm_healthy", 32'(arrived_want.confirm_healthy),
                            32'(confirm_healthy));
                match_field("sleep_blocked", 32'(arrived_want.sleep_blocked),
                            32'(sleep_blocked));
                match_field("announce_cmd", 32'(arrived_want.announce_cmd),
                            32'(announce_cmd));
                match_field("joined_now", 32'(arrived_want.joined_now), 32'(joined_now));
                match_field("retry_interval", 32'(arrived_want.retry_interval),
                            32'(retry_interval));
                results_seen++;
                joins_seen    += 32'(join_request);
                clears_seen   += 32'(clear_net_state);
                resets_seen   += 32'(system_reset);
                confirms_seen += 32'(confirm_healthy);
            end
        end
    end

    // Hard limit on the run, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("** link_rejoin_supervisor: FAILED **");
        $finish;
    end

    initial
    begin
        // The directed script runs on the register values after reset. It first looks at
        // the reset state, then walks a join attempt through a stalled join, a stack that is
        // still joined, a transitional stack and interval saturation, followed by a join,
        // send failures up to the limit, the health confirmation, a stale coordinator and
        // finally a give-up across the wrap of the millisecond counter. The boot timeout on
        // probation comes early because it can only fire while health is unconfirmed.
        script_add(ACT_TICK, 32'd0, 1'b0, ST_NET_UP, 1'b0, NS_TRANS, 1'b0, 1'b0);
        script_pin(make_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ANN_NONE, 1'b0, RST_RETRY_MIN));
        script_add(ACT_START, 32'd1000, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_pin(make_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ANN_NONE, 1'b0, RST_RETRY_MIN));
        script_add(ACT_TICK, 32'd180000, 1'b0, ST_NET_UP, 1'b0, NS_TRANS, 1'b0, 1'b1);
        script_pin(make_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, ANN_NONE, 1'b0, RST_RETRY_MIN));
        script_add(ACT_TICK, 32'd180300, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b1, 1'b0);
        script_add(ACT_TICK, 32'd196000, 1'b0, ST_NET_UP, 1'b0, NS_TRANS, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'd198000, 1'b0, ST_NET_UP, 1'b0, NS_JOINED, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'd202000, 1'b0, ST_NET_UP, 1'b0, NS_TRANS, 1'b0, 1'b0);
        script_add(ACT_STATUS, 32'd202500, 1'b0, ST_OTHER, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'd210000, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'd226000, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b1, 1'b0);
        script_add(ACT_STATUS, 32'd227000, 1'b0, ST_OTHER, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_STATUS, 32'd228000, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_SEND, 32'd229000, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_SEND, 32'd229100, 1'b1, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_SEND, 32'd229200, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_SEND, 32'd229300, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_SEND, 32'd229400, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_STATUS, 32'd230000, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'd250000, 1'b0, ST_NET_UP, 1'b0, NS_JOINED, 1'b0, 1'b1);
        script_add(ACT_STATUS, 32'd251000, 1'b0, ST_NET_DOWN, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_STATUS, 32'd252000, 1'b0, ST_NET_UP, 1'b1, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'd253000, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_pin(make_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ANN_NONE, 1'b0, RST_RETRY_MIN));
        script_add(ACT_START, 32'hFFFF_FF00, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'hFFFF_FFFF, 1'b1, ST_NET_UP, 1'b0, NS_TRANS, 1'b1, 1'b1);
        script_add(ACT_TICK, 32'h0000_0900, 1'b0, ST_NET_UP, 1'b0, NS_NONE, 1'b0, 1'b0);
        script_add(ACT_TICK, 32'h0000_0900 + 32'd300001, 1'b0, ST_NET_UP, 1'b0, NS_NONE,
                   1'b0, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            deliver(script[i].ev, script[i].pinned, script[i].want);
        end
        in_valid <= 1'b0;
        drain();

        // Random traffic over five register settings: the values after reset, the smallest
        // allowed values, the largest ones, a first delay above the minimum interval, and a
        // random draw. The first 200 events of the largest setting run without any gaps or stalls.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:
                begin
                    apply_settings(16'd1, 16'd1, 16'd0, 32'd1, 4'd1, 32'd1, 32'd1, 32'd1);
                    step_scale = 2;
                end
                2:
                begin
                    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'd15,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    step_scale = 8000;
                end
                3:
                begin
                    apply_settings(16'd500, 16'd8000, 16'd3000, 32'd6000, 4'd2, 32'd60000,
                                   32'd5000, 32'd9000);
                    step_scale = 2500;
                end
                4:
                begin
                    apply_settings(16'($urandom_range(1, 5000)), 16'($urandom_range(1, 40000)),
                                   16'($urandom_range(0, 6000)), $urandom_range(1, 30000),
                                   4'($urandom_range(1, 15)), $urandom_range(1, 200000),
                                   $urandom_range(1, 40000), $urandom_range(1, 100000));
                    step_scale = $urandom_range(100, 5000);
                end
                default: step_scale = 3000;
            endcase
            for (int n = 0; n < 380; n++)
            begin
                steady_span = (phase == 2 && n < 200);
                deliver(next_random_event(), 1'b0, '0);
            end
            steady_span = 1'b0;
            in_valid <= 1'b0;
            drain();
        end

        $display("Run covered %0d event beats over five register settings; %0d results checked.",
                 beats_sent, results_seen);
        $display("Outputs raised: %0d joins, %0d clears, %0d system resets, %0d confirmations.",
                 joins_seen, clears_seen, resets_seen, confirms_seen);
        if (error_count == 0)
        begin
            $display("** link_rejoin_supervisor: PASSED **");
        end
        else
        begin
            $display("** link_rejoin_supervisor: FAILED **");
        end
        $finish;
    end

endmodule
